FILE: hdl/sfq7_pkg.sv
// ----------------------------------------------------------------------------
// sfq7_pkg
// Shared types and constants for the sparse Q7 FIR filter.
// ----------------------------------------------------------------------------
package sfq7_pkg;

    localparam int SampleW   = 8;
    localparam int HistDepth = 256;
    localparam int AddrW     = $clog2(HistDepth);
    localparam int NumTaps   = 8;
    localparam int TapW      = $clog2(NumTaps);
    localparam int ProdW     = 2 * SampleW;
    localparam int AccW      = ProdW + TapW;
    localparam int Frac      = 7;
    localparam int PackW     = NumTaps * SampleW;
    localparam int CfgIdxW   = 2;
    localparam int TapsRegW  = 4;

    localparam logic [CfgIdxW-1:0] CFG_NUM_TAPS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_COEFF_PACK = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DELAY_PACK = 2'd2;

    localparam logic signed [SampleW-1:0] SAT_MAX = 8'sd127;
    localparam logic signed [SampleW-1:0] SAT_MIN = -8'sd128;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic clear;
        logic en;
    } mac_ctl_t;

endpackage

FILE: hdl/sfq7_hist_mem.sv
// ----------------------------------------------------------------------------
// sfq7_hist_mem
// Sample history: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sfq7_hist_mem (
    input  logic                             clk,
    input  logic                             we,
    input  logic [sfq7_pkg::AddrW-1:0]       waddr,
    input  logic signed [sfq7_pkg::SampleW-1:0] wdata,
    input  logic [sfq7_pkg::AddrW-1:0]       raddr,
    output logic signed [sfq7_pkg::SampleW-1:0] rdata
);

    logic signed [sfq7_pkg::SampleW-1:0] mem [sfq7_pkg::HistDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sfq7_mac.sv
// ----------------------------------------------------------------------------
// sfq7_mac
// Multiply-accumulate over the taps, then arithmetic shift and saturation.
// ----------------------------------------------------------------------------
module sfq7_mac (
    input  logic                                clk,
    input  sfq7_pkg::mac_ctl_t                  ctl,
    input  logic signed [sfq7_pkg::SampleW-1:0] coef,
    input  logic signed [sfq7_pkg::SampleW-1:0] sample,
    output logic signed [sfq7_pkg::SampleW-1:0] result
);

    localparam int ShW = sfq7_pkg::AccW - sfq7_pkg::Frac;

    logic signed [sfq7_pkg::AccW-1:0]  acc_reg;
    logic signed [sfq7_pkg::ProdW-1:0] prod;
    logic signed [ShW-1:0]             shifted;

    assign prod    = coef * sample;
    assign shifted = ShW'(acc_reg >>> sfq7_pkg::Frac);

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.en)
        begin
            acc_reg <= acc_reg + sfq7_pkg::AccW'(prod);
        end
    end

    // saturate to the Q7 range
    always_comb
    begin
        if (shifted > ShW'(sfq7_pkg::SAT_MAX))
        begin
            result = sfq7_pkg::SAT_MAX;
        end
        else if (shifted < ShW'(sfq7_pkg::SAT_MIN))
        begin
            result = sfq7_pkg::SAT_MIN;
        end
        else
        begin
            result = sfq7_pkg::SampleW'(shifted);
        end
    end

endmodule

FILE: hdl/sparse_fir_q7.sv
// The next sample is taken only once the previous one is through; each active
// tap needs one history read on the single read port of the history memory.
// A finished result waits in the output register while the next sample runs.
// Reset: asynchronous, active low; a clearing pass then zeroes all 256 history
// entries with s_tready low (configuration writes are still taken).
// ----------------------------------------------------------------------------
// sparse_fir_q7
// Sparse FIR filter on signed Q7 samples over a 256-entry circular history.
// ----------------------------------------------------------------------------
module sparse_fir_q7 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] sample_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] sample_out
    input  logic                                cfg_we,
    input  logic [sfq7_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [sfq7_pkg::PackW-1:0]          cfg_data
);

    sfq7_pkg::state_t                    state_reg;
    logic [sfq7_pkg::AddrW-1:0]          clr_cnt_reg;
    logic [sfq7_pkg::AddrW-1:0]          wp_reg;
    logic [sfq7_pkg::AddrW-1:0]          base_reg;
    logic [sfq7_pkg::TapW-1:0]           k_reg;
    logic [sfq7_pkg::TapW-1:0]           last_reg;
    logic [sfq7_pkg::TapW-1:0]           last_next;
    logic signed [sfq7_pkg::SampleW-1:0] coef_reg;
    logic                                mac_en_reg;
    logic                                m_tvalid_reg;
    logic [sfq7_pkg::SampleW-1:0]        m_tdata_reg;
    logic [sfq7_pkg::TapsRegW-1:0]       num_taps_reg;
    logic [sfq7_pkg::PackW-1:0]          coeff_reg;
    logic [sfq7_pkg::PackW-1:0]          delay_reg;

    logic                                accept;
    logic                                mem_we;
    logic [sfq7_pkg::AddrW-1:0]          mem_waddr;
    logic signed [sfq7_pkg::SampleW-1:0] mem_wdata;
    logic [sfq7_pkg::AddrW-1:0]          mem_raddr;
    logic signed [sfq7_pkg::SampleW-1:0] mem_rdata;
    logic [sfq7_pkg::TapW+2:0]           tap_lsb;
    sfq7_pkg::mac_ctl_t                  mac_ctl;
    logic signed [sfq7_pkg::SampleW-1:0] mac_result;

    assign s_tready = (state_reg == sfq7_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign tap_lsb   = {k_reg, 3'b000};
    assign mem_we    = (state_reg == sfq7_pkg::ST_CLEAR) || accept;
    assign mem_waddr = (state_reg == sfq7_pkg::ST_CLEAR) ? clr_cnt_reg : wp_reg;
    assign mem_wdata = (state_reg == sfq7_pkg::ST_CLEAR) ? '0 : signed'(s_tdata);
    assign mem_raddr = base_reg - delay_reg[tap_lsb +: sfq7_pkg::SampleW];

    assign mac_ctl.clear = accept;
    assign mac_ctl.en    = mac_en_reg;

    // clamp the tap count to 1..8
    always_comb
    begin
        if (num_taps_reg == '0)
        begin
            last_next = '0;
        end
        else if (num_taps_reg > sfq7_pkg::TapsRegW'(sfq7_pkg::NumTaps))
        begin
            last_next = sfq7_pkg::TapW'(sfq7_pkg::NumTaps - 1);
        end
        else
        begin
            last_next = sfq7_pkg::TapW'(num_taps_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg <= sfq7_pkg::TapsRegW'(1);
            coeff_reg    <= '0;
            delay_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfq7_pkg::CFG_NUM_TAPS:   num_taps_reg <= cfg_data[sfq7_pkg::TapsRegW-1:0];
                sfq7_pkg::CFG_COEFF_PACK: coeff_reg    <= cfg_data;
                sfq7_pkg::CFG_DELAY_PACK: delay_reg    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sfq7_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            wp_reg       <= '0;
            base_reg     <= '0;
            k_reg        <= '0;
            last_reg     <= '0;
            mac_en_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            mac_en_reg <= (state_reg == sfq7_pkg::ST_READ);
            if ((state_reg == sfq7_pkg::ST_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                sfq7_pkg::ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= sfq7_pkg::ST_IDLE;
                    end
                end
                sfq7_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        base_reg  <= wp_reg;
                        wp_reg    <= wp_reg + 1'b1;
                        k_reg     <= '0;
                        last_reg  <= last_next;
                        state_reg <= sfq7_pkg::ST_READ;
                    end
                end
                sfq7_pkg::ST_READ:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == last_reg)
                    begin
                        state_reg <= sfq7_pkg::ST_WAIT;
                    end
                end
                sfq7_pkg::ST_WAIT:
                begin
                    state_reg <= sfq7_pkg::ST_DONE;
                end
                sfq7_pkg::ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= sfq7_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= sfq7_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sfq7_pkg::ST_READ)
        begin
            coef_reg <= signed'(coeff_reg[tap_lsb +: sfq7_pkg::SampleW]);
        end
        if ((state_reg == sfq7_pkg::ST_DONE) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= mac_result;
        end
    end

    sfq7_hist_mem u_hist_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sfq7_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .coef   (coef_reg),
        .sample (mem_rdata),
        .result (mac_result)
    );

endmodule

FILE: hdl/sfq7_checker.sv
// ----------------------------------------------------------------------------
// sfq7_checker
// Port-level checks on the sparse Q7 FIR filter.
// ----------------------------------------------------------------------------
module sfq7_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready
);

    // hold the result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transaction");

    // one sample at a time: busy after each input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // a new result never follows its input in the next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too early");

endmodule

bind sparse_fir_q7 sfq7_checker u_sfq7_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
